// ===== hdl/rws_pkg.sv =====
// rws_pkg: shared widths and codes for the roulette wheel selector
// no dependencies; imported by rws_table, roulette_wheel_selector, selection_checker and the test
`timescale 1ns / 1ps

package rws_pkg;

    localparam int FIT_W      = 16;
    localparam int RND_W      = 16;
    localparam int SEL_W      = 4;
    localparam int POP_CFG_W  = 5;
    localparam int SCALE_SH   = 16;
    localparam int SUM_W      = FIT_W + POP_CFG_W;
    localparam int PROD_W     = SUM_W + RND_W;

    localparam logic [POP_CFG_W-1:0] POP_RESET = 5'd10;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

endpackage

// ===== hdl/rws_table.sv =====
// rws_table: fitness table memory with per-entry valid bits, registered read
// depends on rws_pkg
`timescale 1ns / 1ps

module rws_table
    import rws_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [FIT_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [FIT_W-1:0]  rd_data
);

    logic [FIT_W-1:0] mem [DEPTH];
    logic [FIT_W-1:0] mem_q_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? mem_q_reg : '0;

endmodule

// ===== hdl/roulette_wheel_selector.sv =====
// roulette_wheel_selector: a write item with an index in range goes straight into the table;
// a select item with n entries in use runs a sum pass and then a scan pass that exits early,
// with one table read per cycle in each pass
// one item at a time; the result register lets the next item in while it waits
// reset clears the table to zero and sets population_in_use to 10
`timescale 1ns / 1ps

module roulette_wheel_selector
    import rws_pkg::*;
#(
    parameter int POPULATION = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [3:0]           entry_index,
    input  logic [FIT_W-1:0]     fitness_value,
    input  logic [RND_W-1:0]     random_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SEL_W-1:0]     selected_index,
    input  logic                 cfg_wr_en,
    input  logic [POP_CFG_W-1:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(POPULATION);

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_SCAN, S_DONE} state_t;

    state_t                state_reg, state_next;
    logic [POP_CFG_W-1:0]  pop_reg;
    logic [POP_CFG_W-1:0]  n_reg, n_next;
    logic [POP_CFG_W-1:0]  cnt_reg, cnt_next;
    logic [RND_W-1:0]      rnd_reg, rnd_next;
    logic [SUM_W-1:0]      acc_reg, acc_next;
    logic [PROD_W-1:0]     target_reg, target_next;
    logic                  rd_v_reg, rd_v_next;
    logic [POP_CFG_W-1:0]  rd_idx_reg, rd_idx_next;
    logic                  acc_v_reg, acc_v_next;
    logic [POP_CFG_W-1:0]  acc_idx_reg, acc_idx_next;
    logic [SEL_W-1:0]      result_reg, result_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SEL_W-1:0]      sel_reg, sel_next;

    logic                  tbl_wr_en;
    logic                  tbl_rd_en;
    logic [FIT_W-1:0]      tbl_rd_data;
    logic [POP_CFG_W-1:0]  n_clamp;
    logic [PROD_W-1:0]     scaled;

    rws_table #(
        .DEPTH  (POPULATION),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (IDX_W'(entry_index)),
        .wr_data (fitness_value),
        .rd_en   (tbl_rd_en),
        .rd_addr (IDX_W'(cnt_reg)),
        .rd_data (tbl_rd_data)
    );

    always_comb
    begin
        if (pop_reg == '0)
        begin
            n_clamp = POP_CFG_W'(1);
        end
        else if (32'(pop_reg) > POPULATION)
        begin
            n_clamp = POP_CFG_W'(POPULATION);
        end
        else
        begin
            n_clamp = pop_reg;
        end
    end

    // running sum times 65535
    assign scaled = PROD_W'({acc_reg, {SCALE_SH{1'b0}}}) - PROD_W'(acc_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        rnd_next       = rnd_reg;
        acc_next       = acc_reg;
        target_next    = target_reg;
        rd_v_next      = 1'b0;
        rd_idx_next    = cnt_reg;
        acc_v_next     = 1'b0;
        acc_idx_next   = acc_idx_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        tbl_wr_en      = 1'b0;
        tbl_rd_en      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_SELECT)
                    begin
                        rnd_next   = random_value;
                        n_next     = n_clamp;
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        tbl_wr_en = (32'(entry_index) < POPULATION);
                    end
                end
            end
            S_SUM:
            begin
                if (cnt_reg < n_reg)
                begin
                    tbl_rd_en = 1'b1;
                    rd_v_next = 1'b1;
                    cnt_next  = cnt_reg + POP_CFG_W'(1);
                end
                if (rd_v_reg)
                begin
                    acc_next = acc_reg + SUM_W'(tbl_rd_data);
                end
                if (cnt_reg == n_reg && !rd_v_reg)
                begin
                    target_next = PROD_W'(rnd_reg) * PROD_W'(acc_reg);
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg < n_reg)
                begin
                    tbl_rd_en = 1'b1;
                    rd_v_next = 1'b1;
                    cnt_next  = cnt_reg + POP_CFG_W'(1);
                end
                if (rd_v_reg)
                begin
                    acc_next = acc_reg + SUM_W'(tbl_rd_data);
                end
                acc_v_next   = rd_v_reg;
                acc_idx_next = rd_idx_reg;
                // first hit, or last entry in use as fallback
                if (acc_v_reg &&
                    (scaled >= target_reg || acc_idx_reg == n_reg - POP_CFG_W'(1)))
                begin
                    result_next = acc_idx_reg[SEL_W-1:0];
                    rd_v_next   = 1'b0;
                    acc_v_next  = 1'b0;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sel_next       = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pop_reg       <= POP_RESET;
            n_reg         <= POP_CFG_W'(1);
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            acc_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            rd_v_reg      <= rd_v_next;
            acc_v_reg     <= acc_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pop_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg     <= rnd_next;
        acc_reg     <= acc_next;
        target_reg  <= target_next;
        rd_idx_reg  <= rd_idx_next;
        acc_idx_reg <= acc_idx_next;
        result_reg  <= result_next;
        sel_reg     <= sel_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign selected_index = sel_reg;

    // read pipeline is empty whenever a new item can enter
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!rd_v_reg && !acc_v_reg))
        else $error("read pipeline busy while idle");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM || state_reg == S_SCAN) |-> (cnt_reg <= n_reg && n_reg != '0))
        else $error("scan counter beyond entries in use");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_v_reg |-> (acc_idx_reg < n_reg))
        else $error("compared index beyond entries in use");

    a_last_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && acc_v_reg && acc_idx_reg == n_reg - POP_CFG_W'(1))
        |=> state_reg == S_DONE)
        else $error("scan did not finish at last entry");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("result not presented");

endmodule

// ===== tb/selection_checker.sv =====
// selection_checker: watches the roulette wheel selector channels, predicts each
// selected index from a shadow fitness table and compares; depends on rws_pkg
`timescale 1ns / 1ps

module selection_checker
    import rws_pkg::*;
#(
    parameter int POPULATION = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 mode,
    input  logic [3:0]           entry_index,
    input  logic [FIT_W-1:0]     fitness_value,
    input  logic [RND_W-1:0]     random_value,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [SEL_W-1:0]     selected_index,
    input  logic                 cfg_wr_en,
    input  logic [POP_CFG_W-1:0] cfg_wr_data,
    output int                   error_count,
    output int                   pending
);

    localparam logic [63:0] FULL_SCALE = 64'd65535;

    logic [FIT_W-1:0]     fitness_shadow [POPULATION];
    logic [POP_CFG_W-1:0] population_setting;
    logic [SEL_W-1:0]     expected_picks [$];
    int                   mismatches;

    function automatic logic [SEL_W-1:0] pick_index(input logic [RND_W-1:0] frac);
        int               in_use;
        int               i;
        int               last;
        logic [63:0]      total;
        logic [63:0]      running;
        logic [63:0]      target;
        logic [SEL_W-1:0] pick;
        logic             found;
        in_use = int'(population_setting);
        if (in_use < 1)
            in_use = 1;
        if (in_use > POPULATION)
            in_use = POPULATION;
        total = '0;
        for (i = 0; i < in_use; i++)
            total += 64'(fitness_shadow[i]);
        target = 64'(frac) * total;
        running = '0;
        found = 1'b0;
        last = in_use - 1;
        pick = last[SEL_W-1:0];
        for (i = 0; i < in_use; i++)
        begin
            running += 64'(fitness_shadow[i]);
            if (!found && running * FULL_SCALE >= target)
            begin
                pick = i[SEL_W-1:0];
                found = 1'b1;
            end
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [SEL_W-1:0] want;
        if (!rst_n)
        begin
            for (int k = 0; k < POPULATION; k++)
                fitness_shadow[k] = '0;
            population_setting = POP_RESET;
            expected_picks.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_wr_en)
                population_setting = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (expected_picks.size() == 0)
                begin
                    $error("selected_index: expected none, actual %0d", selected_index);
                    mismatches++;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (selected_index !== want)
                    begin
                        $error("selected_index: expected %0d, actual %0d",
                               want, selected_index);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_WRITE)
                begin
                    if (entry_index < POPULATION)
                        fitness_shadow[entry_index] = fitness_value;
                end
                else
                    expected_picks = {expected_picks, pick_index(random_value)};
            end
        end
        pending <= expected_picks.size();
        error_count <= mismatches;
    end

endmodule

// ===== tb/roulette_wheel_selector_test.sv =====
// roulette_wheel_selector_test: drives write and select transfers with random
// idling and population settings; depends on rws_pkg, roulette_wheel_selector
// and selection_checker
`timescale 1ns / 1ps

module roulette_wheel_selector_test;
    import rws_pkg::*;

    localparam int POPULATION    = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int SEGMENT_ITEMS = 113;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 mode = MODE_WRITE;
    logic [3:0]           entry_index = '0;
    logic [FIT_W-1:0]     fitness_value = '0;
    logic [RND_W-1:0]     random_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [SEL_W-1:0]     selected_index;
    logic                 cfg_wr_en = 1'b0;
    logic [POP_CFG_W-1:0] cfg_wr_data = '0;

    int error_count;
    int pending;
    int send_idle = 26;
    int recv_idle = 80;
    int current_pop = int'(POP_RESET);
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    roulette_wheel_selector #(.POPULATION(POPULATION)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .entry_index    (entry_index),
        .fitness_value  (fitness_value),
        .random_value   (random_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .selected_index (selected_index),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    selection_checker #(.POPULATION(POPULATION)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .entry_index    (entry_index),
        .fitness_value  (fitness_value),
        .random_value   (random_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .selected_index (selected_index),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .error_count    (error_count),
        .pending        (pending)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input logic item_mode, input logic [3:0] item_entry,
                             input logic [FIT_W-1:0] item_fit,
                             input logic [RND_W-1:0] item_rnd);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= item_mode;
        entry_index <= item_entry;
        fitness_value <= item_fit;
        random_value <= item_rnd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_population(input logic [POP_CFG_W-1:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        current_pop = int'(value);
    endtask

    task automatic random_item();
        logic             m;
        logic [3:0]       e;
        logic [FIT_W-1:0] f;
        logic [RND_W-1:0] r;
        int               in_use;
        in_use = current_pop;
        if (in_use < 1)
            in_use = 1;
        if (in_use > POPULATION)
            in_use = POPULATION;
        m = ($urandom_range(99) < 45) ? MODE_SELECT : MODE_WRITE;
        if ($urandom_range(9) < 7)
            e = 4'($urandom_range(in_use - 1));
        else
            e = 4'($urandom_range(15));
        case ($urandom_range(9))
            0: f = '0;
            1: f = '1;
            2: f = FIT_W'($urandom_range(15));
            default: f = FIT_W'($urandom);
        endcase
        case ($urandom_range(7))
            0: r = '0;
            1: r = '1;
            default: r = RND_W'($urandom);
        endcase
        send_item(m, e, f, r);
    endtask

    initial
    begin
        logic [POP_CFG_W-1:0] seg_pop [6];
        seg_pop[0] = 5'd16;
        seg_pop[1] = 5'd1;
        seg_pop[2] = 5'd5;
        seg_pop[3] = 5'd31;
        seg_pop[4] = POP_CFG_W'($urandom_range(2, 15));
        seg_pop[5] = 5'd0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset population, empty table
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'h0000);
        send_item(MODE_SELECT, 4'd15, 16'hFFFF, 16'hFFFF);
        send_item(MODE_WRITE, 4'd0, 16'hFFFF, 16'hFFFF);
        send_item(MODE_WRITE, 4'd15, 16'hFFFF, 16'h0000);
        send_item(MODE_WRITE, 4'd9, 16'h0001, 16'hA5A5);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'h0000);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'hFFFF);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'hFFFE);
        send_item(MODE_WRITE, 4'd0, 16'h0000, 16'h5A5A);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'h0000);
        send_item(MODE_SELECT, 4'd15, 16'hFFFF, 16'h0001);
        send_item(MODE_WRITE, 4'd5, 16'h5555, 16'h0000);
        send_item(MODE_WRITE, 4'd10, 16'hAAAA, 16'h0000);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'h8000);

        // zero population acts as one entry
        set_population(5'd0);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'hFFFF);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'h0000);

        // oversized population clamps to the table size
        set_population(5'd31);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'hFFFF);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'h7FFF);
        set_population(5'd17);
        send_item(MODE_SELECT, 4'd0, 16'h0000, 16'h4000);

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle = 26;
                    recv_idle = 80;
                end
                1:
                begin
                    send_idle = 80;
                    recv_idle = 26;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            set_population(seg_pop[seg]);
            repeat (SEGMENT_ITEMS) random_item();
        end

        drain();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
